>>> hw/rtl/ccod_pkg.sv
// Shared types and constants for the CC attach and orientation debounce block.
// Depends on nothing; every other file in this block imports it.
`default_nettype none

package ccod_pkg;

  localparam int unsigned CodeW  = 12;
  localparam int unsigned TicksW = 20;
  localparam int unsigned CfgW   = 20;

  localparam logic [CodeW-1:0]  ThreshLowRst  = CodeW'(300 * 4095 / 3300);
  localparam logic [CodeW-1:0]  ThreshHighRst = CodeW'(2200 * 4095 / 3300);
  localparam logic [TicksW-1:0] DebounceRst   = TicksW'(40000);

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_TICK   = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    REG_THRESH_LOW  = 2'd0,
    REG_THRESH_HIGH = 2'd1,
    REG_DEBOUNCE    = 2'd2,
    REG_NONE        = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    LEVEL_LOW     = 2'd0,
    LEVEL_CONN    = 2'd1,
    LEVEL_HIGH    = 2'd2,
    LEVEL_UNKNOWN = 2'd3
  } level_e;

  typedef enum logic [1:0] {
    ORIENT_NONE = 2'd0,
    ORIENT_CC1  = 2'd1,
    ORIENT_CC2  = 2'd2,
    ORIENT_RSVD = 2'd3
  } orient_e;

  typedef struct packed {
    logic             opcode;
    logic             line_select;
    logic [CodeW-1:0] sample_code;
  } in_req_t;

  typedef struct packed {
    logic [1:0] active_orientation;
    logic [1:0] pending_orientation;
    logic       orientation_changed;
  } out_rsp_t;

endpackage

`default_nettype wire

>>> hw/rtl/cc_attach_orientation_debounce_core.sv
// Top level of the CC attach and orientation debounce block.
// Depends on ccod_pkg for the request and response types and reset constants.
// A response is registered in the output entry or the skid entry. Throughput:
// one request per cycle while the skid entry is empty; a two-entry output
// register keeps input accepting while one response waits downstream.
// Reset clears line levels to unknown, orientations to none and the countdown.
`default_nettype none

module cc_attach_orientation_debounce_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [19:0]        cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire ccod_pkg::in_req_t  in_req_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output ccod_pkg::out_rsp_t      out_rsp_o
);
  import ccod_pkg::*;

  logic [CodeW-1:0]  thr_low_q, thr_high_q;
  logic [TicksW-1:0] deb_ticks_q;
  level_e            lvl_q [2];
  level_e            lvl_d [2];
  orient_e           active_q, active_d, pending_q, pending_d, next_orient;
  logic [TicksW-1:0] cnt_q, cnt_d, start_val;
  level_e            new_lvl;
  logic              changed;
  logic              accept, out_free;
  out_rsp_t          res, out_q, skid_q;
  logic              out_valid_q, skid_valid_q;

  assign accept     = in_valid_i & in_ready_o;
  assign in_ready_o = ~skid_valid_q;
  assign out_free   = ~out_valid_q | out_ready_i;
  assign start_val  = (deb_ticks_q == '0) ? TicksW'(1) : deb_ticks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_low_q   <= ThreshLowRst;
      thr_high_q  <= ThreshHighRst;
      deb_ticks_q <= DebounceRst;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_THRESH_LOW:  thr_low_q   <= cfg_wdata_i[CodeW-1:0];
        REG_THRESH_HIGH: thr_high_q  <= cfg_wdata_i[CodeW-1:0];
        REG_DEBOUNCE:    deb_ticks_q <= cfg_wdata_i[TicksW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (in_req_i.sample_code < thr_low_q) begin
      new_lvl = LEVEL_LOW;
    end else if (in_req_i.sample_code > thr_high_q) begin
      new_lvl = LEVEL_HIGH;
    end else begin
      new_lvl = LEVEL_CONN;
    end

    lvl_d[0] = lvl_q[0];
    lvl_d[1] = lvl_q[1];
    if (in_req_i.line_select) begin
      lvl_d[1] = new_lvl;
    end else begin
      lvl_d[0] = new_lvl;
    end

    // A level of even parity is low or high; unknown counts as odd.
    if (lvl_d[0] == LEVEL_CONN && !lvl_d[1][0]) begin
      next_orient = ORIENT_CC1;
    end else if (!lvl_d[0][0] && lvl_d[1] == LEVEL_CONN) begin
      next_orient = ORIENT_CC2;
    end else begin
      next_orient = ORIENT_NONE;
    end

    active_d  = active_q;
    pending_d = pending_q;
    cnt_d     = cnt_q;
    changed   = 1'b0;
    case (opcode_e'(in_req_i.opcode))
      OP_SAMPLE: begin
        if (next_orient != pending_q) begin
          pending_d = next_orient;
          if (pending_q != active_q && next_orient == active_q) begin
            cnt_d = '0;
          end else begin
            cnt_d = start_val;
          end
        end
      end
      OP_TICK: begin
        if (cnt_q != '0) begin
          cnt_d = cnt_q - TicksW'(1);
          if (cnt_q == TicksW'(1)) begin
            active_d = pending_q;
            changed  = 1'b1;
          end
        end
      end
      default: ;
    endcase

    res.active_orientation  = active_d;
    res.pending_orientation = pending_d;
    res.orientation_changed = changed;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q[0]  <= LEVEL_UNKNOWN;
      lvl_q[1]  <= LEVEL_UNKNOWN;
      active_q  <= ORIENT_NONE;
      pending_q <= ORIENT_NONE;
      cnt_q     <= '0;
    end else if (accept) begin
      if (in_req_i.opcode == OP_SAMPLE) begin
        lvl_q[0] <= lvl_d[0];
        lvl_q[1] <= lvl_d[1];
      end
      active_q  <= active_d;
      pending_q <= pending_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= accept;
      end
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (accept) begin
        out_q <= res;
      end
    end else if (accept) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

`default_nettype wire

>>> hw/rtl/ccod_checker.sv
// Port-level checker for the CC attach and orientation debounce block.
// Depends on ccod_pkg; bound to cc_attach_orientation_debounce_core below.
`default_nettype none

module ccod_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               cfg_we_i,
  input wire logic [1:0]         cfg_idx_i,
  input wire logic [19:0]        cfg_wdata_i,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire ccod_pkg::in_req_t  in_req_i,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire ccod_pkg::out_rsp_t out_rsp_o
);
  import ccod_pkg::*;

  a_accept_gives_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted request left no response");

  a_full_means_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no response waiting");

  a_changed_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.orientation_changed
      |-> out_rsp_o.active_orientation == out_rsp_o.pending_orientation)
    else $error("change flagged but active differs from pending");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled response changed");

endmodule

bind cc_attach_orientation_debounce_core ccod_checker u_ccod_checker (.*);

`default_nettype wire
